>>> hdl/zcms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zcms_pkg
// Shared types, constants and a helper function of the zero contour tracer.
// ----------------------------------------------------------------------------
package zcms_pkg;

    localparam int GRID_MAX_DEFAULT = 256;
    localparam int SEG_LIMIT_DEFAULT = 10000;

    // Grid coordinates: origin plus up to 511 steps of a 31-bit spacing.
    localparam int COORD_W = 42;

    localparam logic [31:0] X_ORIGIN_RST = 32'sd0;
    localparam logic [31:0] Y_TOP_RST = 32'sd65536;
    localparam logic [30:0] X_STEP_RST = 31'd4096;
    localparam logic [30:0] Y_STEP_RST = 31'd4096;
    localparam logic [8:0] GRID_SIZE_RST = 9'd16;
    localparam logic [15:0] SEG_LIMIT_RST = 16'(SEG_LIMIT_DEFAULT);

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_X_ORIGIN = 3'd0;
    localparam logic [2:0] REG_Y_TOP = 3'd1;
    localparam logic [2:0] REG_X_STEP = 3'd2;
    localparam logic [2:0] REG_Y_STEP = 3'd3;
    localparam logic [2:0] REG_GRID_SIZE = 3'd4;
    localparam logic [2:0] REG_SEG_LIMIT = 3'd5;

    typedef struct packed {
        logic signed [31:0] x_origin;
        logic signed [31:0] y_top;
        logic [30:0] x_step;
        logic [30:0] y_step;
        logic [8:0] grid_size;
        logic [15:0] segment_limit;
    } cfg_t;

    // One classified cell handed from the front part to the back part.
    typedef struct packed {
        logic signed [COORD_W-1:0] base_x0;
        logic signed [COORD_W-1:0] base_y0;
        logic signed [COORD_W-1:0] base_x1;
        logic signed [COORD_W-1:0] base_y1;
        logic signed [32:0] neg_a0;
        logic signed [32:0] den0;
        logic signed [31:0] dx0;
        logic signed [31:0] dy0;
        logic signed [32:0] neg_a1;
        logic signed [32:0] den1;
        logic signed [31:0] dx1;
        logic signed [31:0] dy1;
        logic [15:0] seg_num;
    } cell_job_t;

    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -66'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/zcms_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zcms_sample_if / zcms_seg_if
// Valid/ready channels for input samples and output segments.
// ----------------------------------------------------------------------------
interface zcms_sample_if;
    logic valid;
    logic ready;
    logic signed [31:0] sample_value;
    modport source (output valid, output sample_value, input ready);
    modport sink (input valid, input sample_value, output ready);
endinterface

interface zcms_seg_if;
    logic valid;
    logic ready;
    logic signed [31:0] seg_x0;
    logic signed [31:0] seg_y0;
    logic signed [31:0] seg_x1;
    logic signed [31:0] seg_y1;
    logic [15:0] segment_number;
    modport source (output valid, output seg_x0, output seg_y0, output seg_x1,
                    output seg_y1, output segment_number, input ready);
    modport sink (input valid, input seg_x0, input seg_y0, input seg_x1,
                  input seg_y1, input segment_number, output ready);
endinterface

`default_nettype wire

>>> hdl/zero_contour_marching_squares_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zero_contour_marching_squares_unit
// Marching squares tracer of the zero contour over a streamed grid.
// ----------------------------------------------------------------------------
// Samples arrive on s_in in raster order, top row first, n+1 per row and
// n+1 rows per frame, where n is grid_size clamped to 1..GRID_MAX. A sample
// on the top row or in the left column passes the front part's accept,
// line buffer read and cell setup steps; any other sample also passes an
// emit step that classifies its cell. A cell with exactly two crossings
// under the segment limit becomes a segment on m_out; the back part forms
// each of the four coordinates with a multiply step, a restoring divider
// and a result step, so the divider sets the rate when the contour is
// dense. A two-entry queue decouples the parts, and the output register
// holds a segment until the receiver takes it; a stalled receiver fills
// the queue and then stops sample acceptance. Reset restores the register
// defaults and starts a new frame; the line buffer is not cleared.
// Registers are written over APB at byte address 4*index.
// ----------------------------------------------------------------------------
module zero_contour_marching_squares_unit #(
    parameter int GRID_MAX = zcms_pkg::GRID_MAX_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    zcms_sample_if.sink      s_in,
    zcms_seg_if.source       m_out
);
    import zcms_pkg::*;

    cfg_t cfg;
    cell_job_t job;
    logic job_valid, job_ready;

    zcms_cfg u_cfg (.clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
                    .prdata, .pready, .cfg);
    zcms_front #(.GRID_MAX(GRID_MAX)) u_front (.clk, .rst_n, .cfg, .s_in,
                    .job_valid, .job, .job_ready);
    zcms_back u_back (.clk, .rst_n, .job_valid, .job, .job_ready, .m_out);
endmodule

`default_nettype wire

>>> hdl/zcms_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zcms_cfg
// APB register file holding the tracer's geometry and limit registers.
// ----------------------------------------------------------------------------
module zcms_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output zcms_pkg::cfg_t   cfg
);
    import zcms_pkg::*;

    cfg_t cfg_reg;
    logic [2:0] idx;

    assign idx = paddr[4:2];
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_origin <= X_ORIGIN_RST;
            cfg_reg.y_top <= Y_TOP_RST;
            cfg_reg.x_step <= X_STEP_RST;
            cfg_reg.y_step <= Y_STEP_RST;
            cfg_reg.grid_size <= GRID_SIZE_RST;
            cfg_reg.segment_limit <= SEG_LIMIT_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                REG_X_ORIGIN:  cfg_reg.x_origin <= pwdata;
                REG_Y_TOP:     cfg_reg.y_top <= pwdata;
                REG_X_STEP:    cfg_reg.x_step <= pwdata[30:0];
                REG_Y_STEP:    cfg_reg.y_step <= pwdata[30:0];
                REG_GRID_SIZE: cfg_reg.grid_size <= pwdata[8:0];
                REG_SEG_LIMIT: cfg_reg.segment_limit <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_X_ORIGIN:  prdata = cfg_reg.x_origin;
            REG_Y_TOP:     prdata = cfg_reg.y_top;
            REG_X_STEP:    prdata = {1'b0, cfg_reg.x_step};
            REG_Y_STEP:    prdata = {1'b0, cfg_reg.y_step};
            REG_GRID_SIZE: prdata = {23'd0, cfg_reg.grid_size};
            REG_SEG_LIMIT: prdata = {16'd0, cfg_reg.segment_limit};
            default:       prdata = 32'd0;
        endcase
    end
endmodule

`default_nettype wire

>>> hdl/zcms_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zcms_front
// Line buffer, grid counters and cell classification. Emits a job for each
// cell with exactly two crossings that is still under the segment limit.
// ----------------------------------------------------------------------------
module zcms_front #(
    parameter int GRID_MAX = zcms_pkg::GRID_MAX_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire zcms_pkg::cfg_t    cfg,
    zcms_sample_if.sink            s_in,
    output logic                   job_valid,
    output zcms_pkg::cell_job_t    job,
    input  wire logic              job_ready
);
    import zcms_pkg::*;

    localparam int CW = $clog2(GRID_MAX + 1);
    localparam int AW = $clog2(GRID_MAX + 1);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_GEOM, S_EMIT} state_t;

    state_t state_reg;
    logic [CW-1:0] col_reg, row_reg;
    logic [15:0] segcnt_reg;
    logic signed [31:0] lt_reg, lb_reg, v_reg, top_reg;
    logic signed [31:0] mem [GRID_MAX+1];
    logic signed [31:0] rd_reg;
    logic signed [COORD_W-1:0] xl_reg, xr_reg, yt_reg, yb_reg;
    logic [CW-1:0] n_eff;
    cell_job_t job_reg;
    logic job_valid_reg;
    logic cell_reg;
    logic rowp_reg;

    always_comb
    begin
        if (cfg.grid_size == 9'd0)
            n_eff = CW'(1);
        else if (32'(cfg.grid_size) > 32'(GRID_MAX))
            n_eff = CW'(GRID_MAX);
        else
            n_eff = CW'(cfg.grid_size);
    end

    assign s_in.ready = (state_reg == S_IDLE);
    assign job_valid = job_valid_reg;
    assign job = job_reg;

    logic [CW-1:0] c_cl;
    assign c_cl = (32'(col_reg) > 32'(GRID_MAX)) ? CW'(GRID_MAX) : col_reg;

    always_ff @(posedge clk)
    begin
        if (s_in.valid && s_in.ready)
            mem[AW'(c_cl)] <= s_in.sample_value;
        rd_reg <= mem[AW'(c_cl)];
    end

    // Classification of the cell from the four corners.
    logic signed [31:0] pz [4];
    logic signed [COORD_W-1:0] px [4], py [4];
    logic [1:0] ep [4], eq [4];
    logic [2:0] cnt;
    cell_job_t jn;
    always_comb
    begin
        ep[0] = 2'd0; eq[0] = 2'd1;
        ep[1] = 2'd2; eq[1] = 2'd1;
        ep[2] = 2'd2; eq[2] = 2'd3;
        ep[3] = 2'd0; eq[3] = 2'd3;
        pz[0] = lt_reg; pz[1] = top_reg; pz[2] = v_reg; pz[3] = lb_reg;
        px[0] = xl_reg; px[1] = xr_reg; px[2] = xr_reg; px[3] = xl_reg;
        py[0] = yt_reg; py[1] = yt_reg; py[2] = yb_reg; py[3] = yb_reg;
        cnt = 3'd0;
        jn = '0;
        jn.seg_num = segcnt_reg;
        for (int e = 0; e < 4; e++)
        begin
            if (((pz[ep[e]] <= 0 && pz[eq[e]] >= 0) || (pz[ep[e]] >= 0 && pz[eq[e]] <= 0))
                && pz[ep[e]] != pz[eq[e]])
            begin
                if (cnt == 3'd0)
                begin
                    jn.base_x0 = px[ep[e]];
                    jn.base_y0 = py[ep[e]];
                    jn.neg_a0 = -33'(pz[ep[e]]);
                    jn.den0 = 33'(pz[eq[e]]) - 33'(pz[ep[e]]);
                    jn.dx0 = 32'(px[eq[e]] - px[ep[e]]);
                    jn.dy0 = 32'(py[eq[e]] - py[ep[e]]);
                end
                else if (cnt == 3'd1)
                begin
                    jn.base_x1 = px[ep[e]];
                    jn.base_y1 = py[ep[e]];
                    jn.neg_a1 = -33'(pz[ep[e]]);
                    jn.den1 = 33'(pz[eq[e]]) - 33'(pz[ep[e]]);
                    jn.dx1 = 32'(px[eq[e]] - px[ep[e]]);
                    jn.dy1 = 32'(py[eq[e]] - py[ep[e]]);
                end
                cnt = cnt + 3'd1;
            end
        end
    end

    // Column and row positions; the counters never pass 511, so the
    // products stay within 40 bits.
    logic [40:0] cx_prod, ry_prod;
    logic signed [COORD_W-1:0] org_x, org_y, stp_x, stp_y, cx_s, ry_s;
    assign cx_prod = 41'(c_cl) * 41'(cfg.x_step);
    assign ry_prod = 41'(row_reg) * 41'(cfg.y_step);
    assign org_x = COORD_W'($signed(cfg.x_origin));
    assign org_y = COORD_W'($signed(cfg.y_top));
    assign stp_x = COORD_W'(cfg.x_step);
    assign stp_y = COORD_W'(cfg.y_step);
    assign cx_s = COORD_W'(cx_prod);
    assign ry_s = COORD_W'(ry_prod);

    logic frame_end;
    logic job_load;
    assign frame_end = (col_reg == '0) && (row_reg == '0);
    assign job_load = (state_reg == S_EMIT) && (!job_valid_reg || job_ready)
                      && (cnt == 3'd2) && (segcnt_reg < cfg.segment_limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            col_reg <= '0;
            row_reg <= '0;
            segcnt_reg <= '0;
            lt_reg <= '0;
            lb_reg <= '0;
            v_reg <= '0;
            top_reg <= '0;
            xl_reg <= '0;
            xr_reg <= '0;
            yt_reg <= '0;
            yb_reg <= '0;
            job_reg <= '0;
            job_valid_reg <= 1'b0;
            cell_reg <= 1'b0;
            rowp_reg <= 1'b0;
        end
        else
        begin
            if (job_load)
                job_valid_reg <= 1'b1;
            else if (job_ready)
                job_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_in.valid)
                    begin
                        v_reg <= s_in.sample_value;
                        cell_reg <= (row_reg != '0) && (c_cl != '0);
                        rowp_reg <= (row_reg != '0);
                        // Coordinates stay exact: 42 bits cover every cell.
                        xr_reg <= org_x + cx_s;
                        xl_reg <= org_x + cx_s - stp_x;
                        yb_reg <= org_y - ry_s;
                        yt_reg <= org_y - ry_s + stp_y;
                        if (c_cl >= n_eff)
                        begin
                            col_reg <= '0;
                            row_reg <= (row_reg >= n_eff) ? '0 : row_reg + CW'(1);
                        end
                        else
                        begin
                            col_reg <= c_cl + CW'(1);
                        end
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    top_reg <= rd_reg;
                    state_reg <= S_GEOM;
                end
                S_GEOM:
                begin
                    if (cell_reg)
                        state_reg <= S_EMIT;
                    else
                    begin
                        state_reg <= S_IDLE;
                        // Left corners update on every sample of a non-top row.
                        if (rowp_reg)
                        begin
                            lt_reg <= top_reg;
                            lb_reg <= v_reg;
                        end
                        if (frame_end)
                            segcnt_reg <= '0;
                    end
                end
                S_EMIT:
                begin
                    if (!job_valid_reg || job_ready)
                    begin
                        lt_reg <= top_reg;
                        lb_reg <= v_reg;
                        if (job_load)
                        begin
                            job_reg <= jn;
                            segcnt_reg <= frame_end ? '0 : segcnt_reg + 16'd1;
                        end
                        else if (frame_end)
                        begin
                            segcnt_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg && !job_ready |=> job_valid_reg && $stable(job_reg))
        else $error("job changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        s_in.ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> $past(state_reg) == S_IDLE)
        else $error("bad state order");
`endif
endmodule

`default_nettype wire

>>> hdl/zcms_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zcms_back
// Two-entry job queue, multiply and radix-2 division per crossing coordinate,
// saturation and an output register.
// ----------------------------------------------------------------------------
module zcms_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             job_valid,
    input  wire zcms_pkg::cell_job_t job,
    output logic                  job_ready,
    zcms_seg_if.source            m_out
);
    import zcms_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_MUL, B_DIV, B_NEXT, B_OUT} state_t;

    cell_job_t q_reg [2];
    logic [1:0] cnt_reg;
    logic wp_reg, rp_reg;
    state_t state_reg;
    cell_job_t cur_reg;
    logic [1:0] k_reg;
    logic signed [65:0] prod_reg;
    logic [65:0] rem_reg, quo_reg, mag_reg;
    logic [32:0] dmag_reg;
    logic neg_reg;
    logic [6:0] bit_reg;
    logic [31:0] res_reg [4];
    logic out_valid_reg;

    logic push, pop, out_load;
    assign job_ready = (cnt_reg != 2'd2);
    assign push = job_valid && job_ready;
    assign pop = (state_reg == B_IDLE) && (cnt_reg != 2'd0);
    assign out_load = (state_reg == B_OUT) && (!out_valid_reg || m_out.ready);

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= job;
    end

    // Operand selection for coordinate k.
    logic signed [32:0] na, dn;
    logic signed [COORD_W-1:0] base;
    logic signed [31:0] d;
    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                na = cur_reg.neg_a0;
                dn = cur_reg.den0;
                d = cur_reg.dx0;
                base = cur_reg.base_x0;
            end
            2'd1:
            begin
                na = cur_reg.neg_a0;
                dn = cur_reg.den0;
                d = cur_reg.dy0;
                base = cur_reg.base_y0;
            end
            2'd2:
            begin
                na = cur_reg.neg_a1;
                dn = cur_reg.den1;
                d = cur_reg.dx1;
                base = cur_reg.base_x1;
            end
            default:
            begin
                na = cur_reg.neg_a1;
                dn = cur_reg.den1;
                d = cur_reg.dy1;
                base = cur_reg.base_y1;
            end
        endcase
    end

    logic [66:0] trial;
    assign trial = {rem_reg, mag_reg[65]} - {34'd0, dmag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            state_reg <= B_IDLE;
            out_valid_reg <= 1'b0;
            cur_reg <= '0;
            k_reg <= '0;
            prod_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
            mag_reg <= '0;
            dmag_reg <= '0;
            neg_reg <= 1'b0;
            bit_reg <= '0;
            res_reg <= '{default: '0};
        end
        else
        begin
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
            if (push)
                wp_reg <= ~wp_reg;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_out.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        cur_reg <= q_reg[rp_reg];
                        rp_reg <= ~rp_reg;
                        k_reg <= 2'd0;
                        state_reg <= B_MUL;
                    end
                end
                B_MUL:
                begin
                    prod_reg <= 66'(na) * 66'(d);
                    dmag_reg <= dn[32] ? 33'(-dn) : 33'(dn);
                    state_reg <= B_DIV;
                    bit_reg <= 7'd0;
                    rem_reg <= '0;
                    quo_reg <= '0;
                end
                B_DIV:
                begin
                    if (bit_reg == 7'd0)
                    begin
                        mag_reg <= prod_reg[65] ? 66'(-prod_reg) : 66'(prod_reg);
                        neg_reg <= prod_reg[65] ^ dn[32];
                        bit_reg <= 7'd1;
                    end
                    else
                    begin
                        if (!trial[66])
                        begin
                            rem_reg <= trial[65:0];
                            quo_reg <= {quo_reg[64:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[64:0], mag_reg[65]};
                            quo_reg <= {quo_reg[64:0], 1'b0};
                        end
                        mag_reg <= {mag_reg[64:0], 1'b0};
                        if (bit_reg == 7'd66)
                            state_reg <= B_NEXT;
                        else
                            bit_reg <= bit_reg + 7'd1;
                    end
                end
                B_NEXT:
                begin
                    res_reg[k_reg] <= sat32(66'(base) +
                        (neg_reg ? 66'(-$signed(quo_reg)) : $signed(quo_reg)));
                    if (k_reg == 2'd3)
                        state_reg <= B_OUT;
                    else
                    begin
                        k_reg <= k_reg + 2'd1;
                        state_reg <= B_MUL;
                    end
                end
                B_OUT:
                begin
                    if (out_load)
                        state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    logic [31:0] o_reg [4];
    logic [15:0] on_reg;
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_reg <= res_reg;
            on_reg <= cur_reg.seg_num;
        end
    end

    assign m_out.valid = out_valid_reg;
    assign m_out.seg_x0 = o_reg[0];
    assign m_out.seg_y0 = o_reg[1];
    assign m_out.seg_x1 = o_reg[2];
    assign m_out.seg_y1 = o_reg[3];
    assign m_out.segment_number = on_reg;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != 2'd0)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid)
        else $error("segment dropped under stall");
`endif
endmodule

`default_nettype wire
